FILE: rtl/ipwc_pkg.sv
// Package: shared constants, types and helpers for the IR pulse-width capture unit
package ipwc_pkg;

    localparam int BUF_DEPTH   = 128;
    localparam int TIMER_WIDTH = 16;

    localparam int GAP_W    = 16;
    localparam int IDX_W    = 7;
    localparam int RVAL_W   = 16;
    localparam int ECNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W  = (TIMER_WIDTH > GAP_W) ? TIMER_WIDTH : GAP_W;
    localparam int RSAT_W = (TIMER_WIDTH > RVAL_W) ? TIMER_WIDTH : RVAL_W;
    localparam int ESAT_W = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
    localparam int RIDX_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(100);

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_MARK     = 3'd1,
        MODE_SPACE    = 3'd2,
        MODE_STOP     = 3'd3,
        MODE_OVERFLOW = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_RESUME = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_TICKS    = 2'd0,
        CFG_MARK_LEVEL   = 2'd1,
        CFG_BLINK_ENABLE = 2'd2
    } cfg_idx_t;

    // Buffer write request
    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [TIMER_WIDTH-1:0] data;
    } wr_req_t;

    // Status after one item, carried down the result pipeline
    typedef struct packed {
        mode_t             capture_state;
        logic              overflow;
        logic [ECNT_W-1:0] entry_count;
        logic              led;
        logic              rd_sel;
    } meta_t;

    // Stored width clipped to the 16-bit result field
    function automatic logic [RVAL_W-1:0] sat_width(input logic [TIMER_WIDTH-1:0] v);
        logic [RSAT_W-1:0] ext;
        ext = RSAT_W'(v);
        if (ext > RSAT_W'({RVAL_W{1'b1}}))
            return {RVAL_W{1'b1}};
        else
            return ext[RVAL_W-1:0];
    endfunction

    // Entry count clipped to the 8-bit result field
    function automatic logic [ECNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [ESAT_W-1:0] ext;
        ext = ESAT_W'(v);
        if (ext > ESAT_W'({ECNT_W{1'b1}}))
            return {ECNT_W{1'b1}};
        else
            return ext[ECNT_W-1:0];
    endfunction

endpackage

FILE: rtl/ipwc_if.sv
// Interfaces: input item channel and result channel
interface ipwc_in_if;
    import ipwc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic              ir_level;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, action, ir_level, read_index, input ready);
    modport sink   (input valid, action, ir_level, read_index, output ready);
endinterface

interface ipwc_out_if;
    import ipwc_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        capture_state;
    logic              frame_ready;
    logic              overflow_flag;
    logic [ECNT_W-1:0] entry_count;
    logic [RVAL_W-1:0] read_value;
    logic              led_on;

    modport source (output valid, capture_state, frame_ready, overflow_flag, entry_count,
                    read_value, led_on, input ready);
    modport sink   (input valid, capture_state, frame_ready, overflow_flag, entry_count,
                    read_value, led_on, output ready);
endinterface

FILE: rtl/ipwc_ctrl.sv
// Capture control: config registers, capture state machine and buffer write requests
module ipwc_ctrl
    import ipwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  item_accept,
    input  logic [1:0]            action,
    input  logic                  ir_level,
    input  logic [IDX_W-1:0]      read_index,
    output wr_req_t               wr,
    output meta_t                 meta_next
);

    logic [GAP_W-1:0]       gap_reg;
    logic                   mark_level_reg;
    logic                   blink_reg;

    mode_t                  mode_reg, mode_next, mode_eff;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next, timer_inc;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   led_reg, led_next;

    logic                   is_mark;
    logic                   gap_met, gap_exceeded;
    logic                   in_range;
    logic                   store;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg        <= GAP_RESET;
            mark_level_reg <= 1'b0;
            blink_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP_TICKS:    gap_reg        <= cfg_wdata[GAP_W-1:0];
                CFG_MARK_LEVEL:   mark_level_reg <= cfg_wdata[0];
                CFG_BLINK_ENABLE: blink_reg      <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Timer step and threshold compares
    always_comb
    begin
        is_mark      = (ir_level == mark_level_reg);
        timer_inc    = (timer_reg == {TIMER_WIDTH{1'b1}}) ? timer_reg : timer_reg + 1'b1;
        gap_met      = CMP_W'(timer_inc) >= CMP_W'(gap_reg);
        gap_exceeded = CMP_W'(timer_inc) > CMP_W'(gap_reg);
        mode_eff     = (count_reg >= CNT_W'(BUF_DEPTH)) ? MODE_OVERFLOW : mode_reg;
        in_range     = RIDX_W'(read_index) < RIDX_W'(BUF_DEPTH);
    end

    // Next state for the accepted item
    always_comb
    begin
        mode_next  = mode_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        led_next   = led_reg;
        store      = 1'b0;

        unique case (action)
            ACT_TICK:
            begin
                timer_next = timer_inc;
                mode_next  = mode_eff;
                unique case (mode_eff)
                    MODE_IDLE:
                    begin
                        if (is_mark)
                        begin
                            timer_next = '0;
                            if (gap_met)
                            begin
                                ovf_next  = 1'b0;
                                store     = 1'b1;
                                mode_next = MODE_MARK;
                            end
                        end
                    end
                    MODE_MARK:
                    begin
                        if (!is_mark)
                        begin
                            store      = 1'b1;
                            timer_next = '0;
                            mode_next  = MODE_SPACE;
                        end
                    end
                    MODE_SPACE:
                    begin
                        if (is_mark)
                        begin
                            store      = 1'b1;
                            timer_next = '0;
                            mode_next  = MODE_MARK;
                        end
                        else if (gap_exceeded)
                        begin
                            mode_next = MODE_STOP;
                        end
                    end
                    MODE_STOP:
                    begin
                        if (is_mark)
                            timer_next = '0;
                    end
                    default:
                    begin
                        ovf_next  = 1'b1;
                        mode_next = MODE_STOP;
                    end
                endcase
                // a new frame always restarts at entry 0
                if (store)
                    count_next = ((mode_eff == MODE_IDLE) ? '0 : count_reg) + 1'b1;
                if (blink_reg)
                    led_next = is_mark;
            end
            ACT_RESUME:
            begin
                mode_next  = MODE_IDLE;
                count_next = '0;
            end
            default: ;
        endcase
    end

    // Buffer write: width at the current fill position
    always_comb
    begin
        wr.en   = item_accept && store;
        wr.addr = (mode_eff == MODE_IDLE) ? '0 : count_reg[ADDR_W-1:0];
        wr.data = timer_inc;
    end

    // Status after the item
    always_comb
    begin
        meta_next.capture_state = mode_next;
        meta_next.overflow      = ovf_next;
        meta_next.entry_count   = sat_count(count_next);
        meta_next.led           = led_next;
        meta_next.rd_sel        = (action == ACT_READ) && in_range;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            timer_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            led_reg   <= 1'b0;
        end
        else if (item_accept)
        begin
            mode_reg  <= mode_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            led_reg   <= led_next;
        end
    end

endmodule

FILE: rtl/ipwc_buf.sv
// Width buffer: single-port-write memory with registered read
module ipwc_buf
    import ipwc_pkg::*;
(
    input  logic                   clk,
    input  wr_req_t                wr,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic [TIMER_WIDTH-1:0] rd_data
);

    logic [TIMER_WIDTH-1:0] mem [BUF_DEPTH];
    logic [TIMER_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ir_pulse_width_capture_unit.sv
// Top level: IR pulse-width capture unit with two-stage result pipeline
//
// Use:
//   req carries one action per transfer: a sample tick (with the receiver
//   level), a read of one buffer entry (read_index) or a resume of capture.
//   rsp returns exactly one result per request, in order: the capture state
//   after the action, frame ready, overflow flag, entry count, the stored
//   width on a read (else 0) and the LED mirror level.
//   Configuration (gap threshold, mark level, blink enable) is written through
//   cfg_we / cfg_index / cfg_wdata while no request is in flight.
// Timing:
//   One request per cycle sustained while rsp.ready is high. A result passes
//   the read stage, then the output register, before it is offered on rsp.
//   The state update and the buffer write both happen in the transfer
//   cycle, so a read right after a tick sees the width.
// Reset:
//   State idle, timer and counts zero, config at defaults. Buffer contents
//   are not cleared; entries read before they are written are undefined.
// Stalls:
//   With rsp.ready low, the output register holds and the read stage fills;
//   req.ready is low while both stages hold a result and rsp.ready stays low.
module ir_pulse_width_capture_unit
    import ipwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ipwc_in_if.sink               req,
    ipwc_out_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                   accept;
    wr_req_t                wr;
    meta_t                  meta_next;
    logic [TIMER_WIDTH-1:0] rd_data;

    logic                   s1_valid_reg;
    meta_t                  s1_meta_reg;
    logic                   s1_adv;

    logic                   out_valid_reg;
    meta_t                  out_meta_reg;
    logic [RVAL_W-1:0]      out_rval_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    ipwc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_accept (accept),
        .action      (req.action),
        .ir_level    (req.ir_level),
        .read_index  (req.read_index),
        .wr          (wr),
        .meta_next   (meta_next)
    );

    ipwc_buf u_buf (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(req.read_index)),
        .rd_data (rd_data)
    );

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_meta_reg <= meta_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_meta_reg <= s1_meta_reg;
            out_rval_reg <= s1_meta_reg.rd_sel ? sat_width(rd_data) : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.capture_state = out_meta_reg.capture_state;
    assign rsp.frame_ready   = (out_meta_reg.capture_state == MODE_STOP);
    assign rsp.overflow_flag = out_meta_reg.overflow;
    assign rsp.entry_count   = out_meta_reg.entry_count;
    assign rsp.read_value    = out_rval_reg;
    assign rsp.led_on        = out_meta_reg.led;

    // Ready only drops with both pipeline stages occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("request stalled with a free pipeline stage");

    // Buffer is written only by an accepted tick
    a_write_tick: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (accept && req.action == ACT_TICK))
        else $error("buffer write without a tick transfer");

    // A stalled result leaves the read stage untouched
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_meta_reg)))
        else $error("read stage lost a pending result");

    // Entry count never passes the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (ESAT_W'(rsp.entry_count) <= ESAT_W'(BUF_DEPTH)))
        else $error("entry count beyond buffer depth");

endmodule
